### rtl/sbce_pkg.sv
// Shared constants, codes and control/status types of the bootload command engine.
package sbce_pkg;

   // Sizes
   localparam int PAGE_BYTES  = 64;
   localparam int FLASH_WORDS = 16384;
   localparam int EEPROM_SIZE = 1024;
   localparam int PAGE_WORDS  = PAGE_BYTES / 2;
   localparam int PAGE_AW     = $clog2(PAGE_WORDS);
   localparam int FLASH_AW    = $clog2(FLASH_WORDS);
   localparam int EE_AW       = $clog2(EEPROM_SIZE);
   localparam int SWEEP_AW    = (FLASH_AW > EE_AW) ? FLASH_AW : EE_AW;
   localparam int CFG_W       = 56;

   // Configuration register indexes
   localparam logic [7:0] REG_NAME      = 8'd0;
   localparam logic [7:0] REG_VERSION   = 8'd1;
   localparam logic [7:0] REG_SIGNATURE = 8'd2;
   localparam logic [7:0] REG_DEVICE    = 8'd3;

   // Reset values of the configuration registers
   localparam logic [55:0] NAME_RESET    = 56'd21745382143898196;
   localparam logic [15:0] VERSION_RESET = 16'd12337;
   localparam logic [23:0] SIG_RESET     = 24'd169246;
   localparam logic [7:0]  DEVICE_RESET  = 8'h73;

   // Command and reply characters
   localparam logic [7:0] CMD_NAME    = "S";
   localparam logic [7:0] CMD_VERSION = "V";
   localparam logic [7:0] CMD_SIG     = "s";
   localparam logic [7:0] CMD_PTYPE   = "p";
   localparam logic [7:0] CMD_DEVLIST = "t";
   localparam logic [7:0] CMD_BUFSUP  = "b";
   localparam logic [7:0] CMD_AUTOINC = "a";
   localparam logic [7:0] CMD_ADDR    = "A";
   localparam logic [7:0] CMD_READ    = "g";
   localparam logic [7:0] CMD_WRITE   = "B";
   localparam logic [7:0] CMD_PROG    = "P";
   localparam logic [7:0] CMD_LEAVE   = "L";
   localparam logic [7:0] CMD_SETDEV  = "T";
   localparam logic [7:0] CMD_SETLED  = "x";
   localparam logic [7:0] CMD_CLRLED  = "y";
   localparam logic [7:0] CMD_ERASE   = "e";
   localparam logic [7:0] CMD_EXIT    = "E";
   localparam logic [7:0] MEM_FLASH   = "F";
   localparam logic [7:0] MEM_EEPROM  = "E";
   localparam logic [7:0] CH_CR       = 8'h0D;
   localparam logic [7:0] CH_UNKNOWN  = "?";
   localparam logic [7:0] CH_YES      = "Y";
   localparam logic [7:0] CH_SER      = "S";
   localparam logic [7:0] CH_PAD      = 8'hFF;

   typedef enum logic [2:0] {
      OUT_FIXED,
      OUT_FLASH_LO,
      OUT_FLASH_HI,
      OUT_EEPROM,
      OUT_CR
   } out_sel_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic        sweep;
      logic        take;
      logic        fill_clear;
      logic        cnt_clear;
      logic        cnt_inc;
      logic        flash_rd;
      logic        ee_rd;
      logic        pkt_rd;
      logic        flash_wr;
      logic        ee_wr;
      logic        addr_inc;
      logic        addr_load;
      logic        addr_add_half;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_last;
   } dp_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic       sweep_last;
      logic       complete;
      logic [7:0] cmd;
      logic [7:0] mem_type;
      logic       size_zero;
      logic       out_free;
      logic       fix_last;
      logic       word_last;
      logic       byte_last;
      logic       page_last;
   } dp_stat_type;

endpackage

### rtl/sbce_datapath.sv
// Datapath: packet header and data stores, address, memories, reply register.
module sbce_datapath import sbce_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  dp_cmd_type        cmd,
   output dp_stat_type       stat,
   input  logic [7:0]        rx_byte,
   input  logic              csr_we,
   input  logic [7:0]        csr_index,
   input  logic [CFG_W-1:0]  csr_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [7:0]        rsp_tx_byte,
   output logic              rsp_last_of_reply
);

   logic [55:0] name_ff;
   logic [15:0] version_ff;
   logic [23:0] sig_ff;
   logic [7:0]  device_ff;

   logic [7:0]  cmd_ff, p1_ff, p2_ff, type_ff;
   logic [6:0]  fill_ff, fill_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [15:0] addr_ff, addr_in;
   logic [SWEEP_AW-1:0] sweep_ff;

   logic [15:0] flash_mem [FLASH_WORDS];
   logic [7:0]  ee_mem [EEPROM_SIZE];
   logic [7:0]  pkt_lo_mem [PAGE_WORDS];
   logic [7:0]  pkt_hi_mem [PAGE_WORDS];
   logic [15:0] flash_rd_ff;
   logic [7:0]  ee_rd_ff, pkt_lo_ff, pkt_hi_ff;

   logic        out_valid_ff;
   logic [7:0]  out_byte_ff;
   logic        out_last_ff;

   logic [6:0]  size;
   logic [6:0]  need;
   logic [3:0]  fix_len;
   logic [7:0]  fix_byte;
   logic [5:0]  data_idx;
   logic [PAGE_AW-1:0] pkt_idx;
   logic [FLASH_AW-1:0] flash_wr_idx;
   logic [7:0]  wr_lo, wr_hi;
   logic [7:0]  out_byte;
   logic [7:0]  twice_cnt;

   // Clamp the packet size to one page
   assign size = (p1_ff != 8'd0 || p2_ff > 8'(PAGE_BYTES)) ? 7'(PAGE_BYTES) : p2_ff[6:0];

   // Length a packet needs before it runs
   always_comb begin
      case (cmd_ff)
         CMD_SETDEV, CMD_SETLED, CMD_CLRLED: need = 7'd2;
         CMD_ADDR:  need = 7'd3;
         CMD_READ:  need = 7'd4;
         CMD_WRITE: need = (fill_ff >= 7'd4) ? 7'd4 + size : 7'd4;
         default:   need = 7'd1;
      endcase
   end

   // Fixed replies: length and byte at position cnt
   always_comb begin
      fix_len  = 4'd1;
      fix_byte = CH_UNKNOWN;
      case (cmd_ff)
         CMD_NAME: begin
            fix_len  = 4'd7;
            fix_byte = 8'(name_ff >> (6'd48 - {cnt_ff[2:0], 3'b000}));
         end
         CMD_VERSION: begin
            fix_len  = 4'd2;
            fix_byte = cnt_ff[0] ? version_ff[7:0] : version_ff[15:8];
         end
         CMD_SIG: begin
            fix_len  = 4'd3;
            fix_byte = (cnt_ff[1:0] == 2'd0) ? sig_ff[23:16] :
                       (cnt_ff[1:0] == 2'd1) ? sig_ff[15:8] : sig_ff[7:0];
         end
         CMD_PTYPE:   fix_byte = CH_SER;
         CMD_DEVLIST: begin
            fix_len  = 4'd2;
            fix_byte = cnt_ff[0] ? 8'd0 : device_ff;
         end
         CMD_BUFSUP: begin
            fix_len  = 4'd3;
            fix_byte = (cnt_ff[1:0] == 2'd0) ? CH_YES :
                       (cnt_ff[1:0] == 2'd1) ? 8'((PAGE_BYTES >> 8) & 255) :
                       8'(PAGE_BYTES & 255);
         end
         CMD_AUTOINC: fix_byte = CH_YES;
         CMD_ADDR, CMD_PROG, CMD_LEAVE, CMD_SETDEV, CMD_SETLED, CMD_CLRLED,
         CMD_ERASE, CMD_EXIT: fix_byte = CH_CR;
         default: fix_byte = CH_UNKNOWN;
      endcase
   end

   assign twice_cnt = {cnt_ff, 1'b0};
   assign data_idx  = 6'(fill_ff - 7'd4);
   assign pkt_idx   = (type_ff == MEM_EEPROM) ? cnt_ff[PAGE_AW:1] : cnt_ff[PAGE_AW-1:0];
   assign flash_wr_idx = {addr_ff[FLASH_AW-1:PAGE_AW],
                          addr_ff[PAGE_AW-1:0] + cnt_ff[PAGE_AW-1:0]};
   assign wr_lo = (twice_cnt < {1'b0, size}) ? pkt_lo_ff : CH_PAD;
   assign wr_hi = (twice_cnt + 8'd1 < {1'b0, size}) ? pkt_hi_ff : CH_PAD;

   // Status toward the controller
   always_comb begin
      stat.sweep_last = &sweep_ff;
      stat.complete   = fill_ff >= need;
      stat.cmd        = cmd_ff;
      stat.mem_type   = type_ff;
      stat.size_zero  = size == 7'd0;
      stat.out_free   = !out_valid_ff || !rsp_stall;
      stat.fix_last   = cnt_ff == 7'({3'b000, fix_len} - 7'd1);
      stat.word_last  = cnt_ff + 7'd1 == 7'((size + 7'd1) >> 1);
      stat.byte_last  = cnt_ff + 7'd1 == size;
      stat.page_last  = cnt_ff == 7'(PAGE_WORDS - 1);
   end

   // Select the next reply byte
   always_comb begin
      case (cmd.out_sel)
         OUT_FIXED:    out_byte = fix_byte;
         OUT_FLASH_LO: out_byte = flash_rd_ff[7:0];
         OUT_FLASH_HI: out_byte = flash_rd_ff[15:8];
         OUT_EEPROM:   out_byte = ee_rd_ff;
         OUT_CR:       out_byte = CH_CR;
         default:      out_byte = CH_CR;
      endcase
   end

   // Next values of counters and address
   always_comb begin
      fill_in = fill_ff;
      if (cmd.fill_clear) begin
         fill_in = 7'd0;
      end else if (cmd.take) begin
         fill_in = fill_ff + 7'd1;
      end
      cnt_in = cnt_ff;
      if (cmd.cnt_clear) begin
         cnt_in = 7'd0;
      end else if (cmd.cnt_inc) begin
         cnt_in = cnt_ff + 7'd1;
      end
      addr_in = addr_ff;
      if (cmd.addr_load) begin
         addr_in = {p1_ff, p2_ff};
      end else if (cmd.addr_inc) begin
         addr_in = addr_ff + 16'd1;
      end else if (cmd.addr_add_half) begin
         addr_in = addr_ff + 16'(size >> 1);
      end
   end

   // Hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         name_ff      <= NAME_RESET;
         version_ff   <= VERSION_RESET;
         sig_ff       <= SIG_RESET;
         device_ff    <= DEVICE_RESET;
         fill_ff      <= '0;
         cnt_ff       <= '0;
         addr_ff      <= '0;
         sweep_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_NAME:      name_ff    <= csr_data[55:0];
               REG_VERSION:   version_ff <= csr_data[15:0];
               REG_SIGNATURE: sig_ff     <= csr_data[23:0];
               REG_DEVICE:    device_ff  <= csr_data[7:0];
               default: ;
            endcase
         end
         fill_ff <= fill_in;
         cnt_ff  <= cnt_in;
         addr_ff <= addr_in;
         if (cmd.sweep) begin
            sweep_ff <= sweep_ff + 1'b1;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Capture header bytes and the reply beat
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         case (fill_ff)
            7'd0: cmd_ff  <= rx_byte;
            7'd1: p1_ff   <= rx_byte;
            7'd2: p2_ff   <= rx_byte;
            7'd3: type_ff <= rx_byte;
            default: ;
         endcase
      end
      if (cmd.out_load) begin
         out_byte_ff <= out_byte;
         out_last_ff <= cmd.out_last;
      end
   end

   // Packet data store, split into even and odd bytes
   always_ff @(posedge clock) begin
      if (cmd.take && fill_ff >= 7'd4) begin
         if (data_idx[0]) begin
            pkt_hi_mem[data_idx[PAGE_AW:1]] <= rx_byte;
         end else begin
            pkt_lo_mem[data_idx[PAGE_AW:1]] <= rx_byte;
         end
      end
      if (cmd.pkt_rd) begin
         pkt_lo_ff <= pkt_lo_mem[pkt_idx];
         pkt_hi_ff <= pkt_hi_mem[pkt_idx];
      end
   end

   // Flash words
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         flash_mem[sweep_ff[FLASH_AW-1:0]] <= 16'hFFFF;
      end else if (cmd.flash_wr) begin
         flash_mem[flash_wr_idx] <= {wr_hi, wr_lo};
      end
      if (cmd.flash_rd) begin
         flash_rd_ff <= flash_mem[addr_ff[FLASH_AW-1:0]];
      end
   end

   // EEPROM bytes
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         ee_mem[sweep_ff[EE_AW-1:0]] <= CH_PAD;
      end else if (cmd.ee_wr) begin
         ee_mem[addr_ff[EE_AW-1:0]] <= cnt_ff[0] ? pkt_hi_ff : pkt_lo_ff;
      end
      if (cmd.ee_rd) begin
         ee_rd_ff <= ee_mem[addr_ff[EE_AW-1:0]];
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tx_byte       = out_byte_ff;
   assign rsp_last_of_reply = out_last_ff;

endmodule

### rtl/sbce_controller.sv
// Controller: sequences byte intake, command dispatch, memory walks and replies.
module sbce_controller import sbce_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_CHECK, ST_FIX,
      ST_RF_ISSUE, ST_RF_LO, ST_RF_HI,
      ST_RE_ISSUE, ST_RE_EMIT,
      ST_WF_RD, ST_WF_WR, ST_WE_RD, ST_WE_WR, ST_ACK
   } state_type;

   state_type state_ff, state_in;

   assign req_stall = state_ff != ST_IDLE;

   // Decode state into datapath commands
   always_comb begin
      cmd         = '0;
      cmd.out_sel = OUT_FIXED;
      state_in    = state_ff;
      case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            state_in = ST_IDLE;
            if (stat.complete) begin
               cmd.fill_clear = 1'b1;
               cmd.cnt_clear  = 1'b1;
               case (stat.cmd)
                  CMD_READ: begin
                     if (!stat.size_zero && stat.mem_type == MEM_FLASH) begin
                        state_in = ST_RF_ISSUE;
                     end else if (!stat.size_zero && stat.mem_type == MEM_EEPROM) begin
                        state_in = ST_RE_ISSUE;
                     end
                  end
                  CMD_WRITE: begin
                     if (stat.mem_type == MEM_FLASH) begin
                        state_in = ST_WF_RD;
                     end else if (stat.mem_type == MEM_EEPROM && !stat.size_zero) begin
                        state_in = ST_WE_RD;
                     end else begin
                        state_in = ST_ACK;
                     end
                  end
                  CMD_ADDR: begin
                     cmd.addr_load = 1'b1;
                     state_in      = ST_FIX;
                  end
                  default: state_in = ST_FIX;
               endcase
            end
         end
         ST_FIX: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = stat.fix_last;
               cmd.cnt_inc  = 1'b1;
               if (stat.fix_last) state_in = ST_IDLE;
            end
         end
         ST_RF_ISSUE: begin
            cmd.flash_rd = 1'b1;
            state_in     = ST_RF_LO;
         end
         ST_RF_LO: begin
            cmd.out_sel = OUT_FLASH_LO;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_RF_HI;
            end
         end
         ST_RF_HI: begin
            cmd.out_sel = OUT_FLASH_HI;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = stat.word_last;
               cmd.addr_inc = 1'b1;
               cmd.cnt_inc  = 1'b1;
               state_in     = stat.word_last ? ST_IDLE : ST_RF_ISSUE;
            end
         end
         ST_RE_ISSUE: begin
            cmd.ee_rd = 1'b1;
            state_in  = ST_RE_EMIT;
         end
         ST_RE_EMIT: begin
            cmd.out_sel = OUT_EEPROM;
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_last = stat.byte_last;
               cmd.addr_inc = 1'b1;
               cmd.cnt_inc  = 1'b1;
               state_in     = stat.byte_last ? ST_IDLE : ST_RE_ISSUE;
            end
         end
         ST_WF_RD: begin
            cmd.pkt_rd = 1'b1;
            state_in   = ST_WF_WR;
         end
         ST_WF_WR: begin
            cmd.flash_wr = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = stat.page_last ? ST_ACK : ST_WF_RD;
         end
         ST_WE_RD: begin
            cmd.pkt_rd = 1'b1;
            state_in   = ST_WE_WR;
         end
         ST_WE_WR: begin
            cmd.ee_wr    = 1'b1;
            cmd.addr_inc = 1'b1;
            cmd.cnt_inc  = 1'b1;
            state_in     = stat.byte_last ? ST_ACK : ST_WE_RD;
         end
         ST_ACK: begin
            cmd.out_sel = OUT_CR;
            if (stat.out_free) begin
               cmd.out_load      = 1'b1;
               cmd.out_last      = 1'b1;
               cmd.addr_add_half = stat.mem_type == MEM_FLASH;
               state_in          = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### rtl/serial_bootload_command_engine_core.sv
// Top level of the serial bootload command engine.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------
//  request  | req_valid/stall    | req_rx_byte
//  response | rsp_valid/stall    | rsp_tx_byte, rsp_last_of_reply
//  config   | csr_valid/ready    | csr_index, csr_data
//
// A host byte is taken when idle, then checked for a complete packet. A
// complete packet emits fixed reply bytes, reads flash words (issue, low
// byte, high byte) or EEPROM bytes (issue, emit), or writes EEPROM bytes or
// each slot of a flash page (read store, write); a memory write adds a carriage
// return beat. After reset a sweep fills flash and EEPROM with ones; no byte
// is accepted until it ends. Response stalls hold the sequencer in place.
module serial_bootload_command_engine_core import sbce_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [7:0]       req_rx_byte,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [7:0]       rsp_tx_byte,
   output logic             rsp_last_of_reply,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_index,
   input  logic [CFG_W-1:0] csr_data
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   assign csr_ready = 1'b1;

   sbce_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   sbce_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .rx_byte           (req_rx_byte),
      .csr_we            (csr_valid & csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_of_reply (rsp_last_of_reply)
   );

endmodule
